/* hw/rtl/dsu_pkg.sv */
// Package: sizes, table entry format, FSM states and shared helpers for the union-find block.
`timescale 1ns / 1ps

package dsu_pkg;

    // Table size and derived widths
    localparam int NUM_ELEMENTS = 1024;
    localparam int IDX_W        = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
    localparam int CNT_W        = $clog2(NUM_ELEMENTS + 1);

    // Fixed field widths of the channels
    localparam int ELEM_W = 10;
    localparam int ROOT_W = 10;
    localparam int SIZE_W = 11;

    localparam logic OP_QUERY = 1'b0;
    localparam logic OP_UNITE = 1'b1;

    // One table entry: a root holds its set size, any other entry its parent index
    typedef struct packed {
        logic             is_root;
        logic [CNT_W-1:0] val;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic              opcode;
        logic [ELEM_W-1:0] elem_a;
        logic [ELEM_W-1:0] elem_b;
    } in_item_t;

    typedef struct packed {
        logic              same_set;
        logic              merged;
        logic [ROOT_W-1:0] root_a;
        logic [SIZE_W-1:0] set_size;
    } out_item_t;

    // Table port request from the sequencer
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic [IDX_W-1:0] raddr;
    } ram_req_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIND_A,
        ST_FIND_B,
        ST_LINK_WIN,
        ST_LINK_LOSE,
        ST_DONE
    } state_t;

    // Out-of-range element indexes saturate to the last entry
    function automatic logic [IDX_W-1:0] clamp_index(input logic [ELEM_W-1:0] v);
        if (32'(v) >= 32'(NUM_ELEMENTS))
            return IDX_W'(NUM_ELEMENTS - 1);
        return IDX_W'(v);
    endfunction

endpackage

/* hw/rtl/dsu_if.sv */
// Valid/ready channel interfaces for the query and answer sides.
`timescale 1ns / 1ps

interface dsu_query_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [9:0]  elem_a;
    logic [9:0]  elem_b;

    modport source (output valid, output opcode, output elem_a, output elem_b, input ready);
    modport sink   (input valid, input opcode, input elem_a, input elem_b, output ready);
endinterface

interface dsu_answer_if;
    logic        valid;
    logic        ready;
    logic        same_set;
    logic        merged;
    logic [9:0]  root_a;
    logic [10:0] set_size;

    modport source (output valid, output same_set, output merged, output root_a,
                    output set_size, input ready);
    modport sink   (input valid, input same_set, input merged, input root_a,
                    input set_size, output ready);
endinterface

/* hw/rtl/dsu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/dsu_ctrl.sv */
// Sequencer: clearing pass, root walks, link writes and result capture.
`timescale 1ns / 1ps

module dsu_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  dsu_pkg::in_item_t in_item,
    output dsu_pkg::ram_req_t ram_req,
    input  dsu_pkg::entry_t   ram_rdata,
    output logic              res_valid,
    input  logic              res_ready,
    output dsu_pkg::out_item_t res_item
);
    import dsu_pkg::*;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic             op_reg, op_next;
    logic [IDX_W-1:0] b_reg, b_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic [IDX_W-1:0] ra_reg, ra_next;
    logic [CNT_W-1:0] sa_reg, sa_next;
    logic [IDX_W-1:0] lose_reg, lose_next;
    logic [IDX_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0] size_reg, size_next;
    logic             same_reg, same_next;
    logic             merged_reg, merged_next;
    logic             same_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        b_reg      <= b_next;
        cur_reg    <= cur_next;
        ra_reg     <= ra_next;
        sa_reg     <= sa_next;
        lose_reg   <= lose_next;
        root_reg   <= root_next;
        size_reg   <= size_next;
        same_reg   <= same_next;
        merged_reg <= merged_next;
    end

    assign same_now = (ra_reg == cur_reg);

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        op_next     = op_reg;
        b_next      = b_reg;
        cur_next    = cur_reg;
        ra_next     = ra_reg;
        sa_next     = sa_reg;
        lose_next   = lose_reg;
        root_next   = root_reg;
        size_next   = size_reg;
        same_next   = same_reg;
        merged_next = merged_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        ram_req     = '0;
        ram_req.raddr = cur_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_req.we            = 1'b1;
                ram_req.waddr         = clr_reg;
                ram_req.wdata.is_root = 1'b1;
                ram_req.wdata.val     = CNT_W'(1);
                clr_next              = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(NUM_ELEMENTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next       = in_item.opcode;
                    b_next        = clamp_index(in_item.elem_b);
                    cur_next      = clamp_index(in_item.elem_a);
                    ram_req.raddr = clamp_index(in_item.elem_a);
                    state_next    = ST_FIND_A;
                end
            end

            ST_FIND_A:
            begin
                if (ram_rdata.is_root)
                begin
                    ra_next       = cur_reg;
                    sa_next       = ram_rdata.val;
                    cur_next      = b_reg;
                    ram_req.raddr = b_reg;
                    state_next    = ST_FIND_B;
                end
                else
                begin
                    cur_next      = ram_rdata.val[IDX_W-1:0];
                    ram_req.raddr = ram_rdata.val[IDX_W-1:0];
                end
            end

            ST_FIND_B:
            begin
                if (ram_rdata.is_root)
                begin
                    same_next = same_now;
                    if (op_reg == OP_UNITE && !same_now)
                    begin
                        // larger set keeps its root; a tie goes to the second root
                        if (sa_reg > ram_rdata.val)
                        begin
                            root_next = ra_reg;
                            lose_next = cur_reg;
                        end
                        else
                        begin
                            root_next = cur_reg;
                            lose_next = ra_reg;
                        end
                        size_next   = CNT_W'(sa_reg + ram_rdata.val);
                        merged_next = 1'b1;
                        state_next  = ST_LINK_WIN;
                    end
                    else
                    begin
                        root_next   = ra_reg;
                        size_next   = sa_reg;
                        merged_next = 1'b0;
                        state_next  = ST_DONE;
                    end
                end
                else
                begin
                    cur_next      = ram_rdata.val[IDX_W-1:0];
                    ram_req.raddr = ram_rdata.val[IDX_W-1:0];
                end
            end

            ST_LINK_WIN:
            begin
                ram_req.we            = 1'b1;
                ram_req.waddr         = root_reg;
                ram_req.wdata.is_root = 1'b1;
                ram_req.wdata.val     = size_reg;
                state_next            = ST_LINK_LOSE;
            end

            ST_LINK_LOSE:
            begin
                ram_req.we            = 1'b1;
                ram_req.waddr         = lose_reg;
                ram_req.wdata.is_root = 1'b0;
                ram_req.wdata.val     = CNT_W'(root_reg);
                state_next            = ST_DONE;
            end

            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    always_comb
    begin
        res_item.same_set = same_reg;
        res_item.merged   = merged_reg;
        res_item.root_a   = ROOT_W'(root_reg);
        res_item.set_size = SIZE_W'(size_reg);
    end

endmodule

/* hw/rtl/disjoint_set_union_find.sv */
// Top level: union-find table with union by size, sequencer, RAM and answer register.
//
//  channel   | dir | transfer payload                         | handshake
//  ----------+-----+------------------------------------------+------------
//  query     | in  | opcode, elem_a, elem_b                   | valid/ready
//  answer    | out | same_set, merged, root_a, set_size       | valid/ready
//
// Per item: accept in ST_IDLE, root walks for elem_a in ST_FIND_A and elem_b in
// ST_FIND_B, link writes in ST_LINK_WIN and ST_LINK_LOSE for a merge, then ST_DONE.
// Walk depth is the parent links to the root, at most log2(NUM_ELEMENTS) under union
// by size. The single table read port paces each walk: one registered read per step.
// Reset: a clearing pass writes every entry as a singleton root, with query.ready
// low throughout.
// Stalls: a finished answer sits in the output register; a new query is taken
// meanwhile, and its result waits until that register frees.
`timescale 1ns / 1ps

module disjoint_set_union_find (
    input  logic         clk,
    input  logic         rst_n,
    dsu_query_if.sink    query,
    dsu_answer_if.source answer
);
    import dsu_pkg::*;

    in_item_t  in_item;
    ram_req_t  ram_req;
    entry_t    ram_rdata;
    logic      res_valid;
    logic      res_ready;
    out_item_t res_item;

    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg, out_item_next;

    always_comb
    begin
        in_item.opcode = query.opcode;
        in_item.elem_a = query.elem_a;
        in_item.elem_b = query.elem_b;
    end

    // Sequencer: walks both roots through the shared table port, then links them on a merge
    dsu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (query.valid),
        .in_ready  (query.ready),
        .in_item   (in_item),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

    // Parent/size table
    dsu_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_ELEMENTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    // Answer register: frees when empty or when the current answer transfers
    assign res_ready = !out_valid_reg || answer.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_item_next  = res_item;
        end
        else if (answer.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign answer.valid    = out_valid_reg;
    assign answer.same_set = out_item_reg.same_set;
    assign answer.merged   = out_item_reg.merged;
    assign answer.root_a   = out_item_reg.root_a;
    assign answer.set_size = out_item_reg.set_size;

endmodule

/* hw/rtl/dsu_checker.sv */
// Port-level assertions for the union-find block, bound to the top level.
`timescale 1ns / 1ps

module dsu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        same_set,
    input logic        merged,
    input logic [10:0] set_size
);

    // a stalled answer stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("answer dropped while stalled");

    // one query at a time: after a transfer the block is busy walking
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("query taken while previous one in progress");

    // a merge never happens between elements already in one set
    a_merge_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(merged && same_set))
        else $error("merged and same_set both set");

    // a merged set holds at least two elements, any set at least one
    a_size_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (set_size != 11'd0) && (!merged || set_size >= 11'd2))
        else $error("set size too small");

endmodule

bind disjoint_set_union_find dsu_checker u_dsu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (query.valid),
    .in_ready  (query.ready),
    .out_valid (answer.valid),
    .out_ready (answer.ready),
    .same_set  (answer.same_set),
    .merged    (answer.merged),
    .set_size  (answer.set_size)
);

/* dv/disjoint_set_union_find_test.sv */
// Self-checking testbench: directed and random query/unite transfers vs. a set-table predictor.
`timescale 1ns / 1ps

module disjoint_set_union_find_test;

    import dsu_pkg::*;

    localparam int     RAND_PER_PHASE = 350;
    localparam int     NUM_PHASES     = 4;
    localparam int     DRAIN_CYCLES   = 40;
    // Slowest run stays under about 720 us; allow over ten times that
    localparam longint RUN_LIMIT_NS   = 64'd10_000_000;

    // Expected answer typed into a directed row, or left to the predictor
    typedef struct packed {
        logic              op;
        logic [ELEM_W-1:0] a;
        logic [ELEM_W-1:0] b;
        bit                typed;
        out_item_t         ans;
    } stim_row_t;

    localparam out_item_t NO_ANS = '0;
    localparam int NUM_ROWS = 20;

    // Answer fields: same_set, merged, root_a, set_size
    localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        // fresh table: every element is its own singleton
        '{OP_QUERY, 10'd0,    10'd0,    1'b1, '{1'b1, 1'b0, 10'd0,    11'd1}},
        '{OP_QUERY, 10'd0,    10'd1023, 1'b1, '{1'b0, 1'b0, 10'd0,    11'd1}},
        '{OP_QUERY, 10'd1023, 10'd0,    1'b1, '{1'b0, 1'b0, 10'd1023, 11'd1}},
        // unite of an element with itself changes nothing
        '{OP_UNITE, 10'd5,    10'd5,    1'b1, '{1'b1, 1'b0, 10'd5,    11'd1}},
        // equal sizes: root of the second element wins
        '{OP_UNITE, 10'd0,    10'd1023, 1'b1, '{1'b0, 1'b1, 10'd1023, 11'd2}},
        // unite on an existing set: no merge
        '{OP_UNITE, 10'd1023, 10'd0,    1'b1, '{1'b1, 1'b0, 10'd1023, 11'd2}},
        '{OP_QUERY, 10'd0,    10'd1023, 1'b1, '{1'b1, 1'b0, 10'd1023, 11'd2}},
        '{OP_UNITE, 10'd1,    10'd2,    1'b1, '{1'b0, 1'b1, 10'd2,    11'd2}},
        // smaller first set joins the larger second one
        '{OP_UNITE, 10'd3,    10'd2,    1'b1, '{1'b0, 1'b1, 10'd2,    11'd3}},
        // larger first set keeps its root
        '{OP_UNITE, 10'd2,    10'd0,    1'b1, '{1'b0, 1'b1, 10'd2,    11'd5}},
        '{OP_QUERY, 10'd1023, 10'd3,    1'b1, '{1'b1, 1'b0, 10'd2,    11'd5}},
        '{OP_UNITE, 10'd682,  10'd341,  1'b1, '{1'b0, 1'b1, 10'd341,  11'd2}},
        '{OP_UNITE, 10'd0,    10'd682,  1'b0, NO_ANS},
        '{OP_QUERY, 10'd341,  10'd1,    1'b0, NO_ANS},
        '{OP_UNITE, 10'd1000, 10'd1001, 1'b0, NO_ANS},
        '{OP_UNITE, 10'd1002, 10'd1003, 1'b0, NO_ANS},
        '{OP_UNITE, 10'd1001, 10'd1003, 1'b0, NO_ANS},
        '{OP_UNITE, 10'd1022, 10'd1000, 1'b0, NO_ANS},
        '{OP_QUERY, 10'd1022, 10'd1003, 1'b0, NO_ANS},
        '{OP_QUERY, 10'd512,  10'd512,  1'b0, NO_ANS}
    };

    localparam int SEND_IDLE_PCT  [NUM_PHASES] = '{0, 57, 0, 26};
    localparam int RECV_STALL_PCT [NUM_PHASES] = '{0, 0, 57, 26};

    logic clk = 1'b0;
    logic rst_n;

    dsu_query_if  query_ch ();
    dsu_answer_if answer_ch ();

    disjoint_set_union_find dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query_ch),
        .answer (answer_ch)
    );

    always #6 clk = ~clk;

    // Predictor state: root entries hold set size, others the parent index
    entry_t    uf_table [NUM_ELEMENTS];
    out_item_t answers_due [$];
    int        mismatch_count = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic void clear_sets();
        for (int i = 0; i < NUM_ELEMENTS; i++)
            uf_table[i] = '{1'b1, CNT_W'(1)};
    endfunction

    function automatic logic [IDX_W-1:0] saturate_elem(input logic [ELEM_W-1:0] v);
        if (int'(v) >= NUM_ELEMENTS)
            return IDX_W'(NUM_ELEMENTS - 1);
        return IDX_W'(v);
    endfunction

    // Walk to the root, then point the walked path straight at it
    function automatic logic [IDX_W-1:0] locate_root(input logic [IDX_W-1:0] x);
        logic [IDX_W-1:0] r;
        logic [IDX_W-1:0] nxt;
        int               hops;
        r    = x;
        hops = 0;
        while (!uf_table[r].is_root && hops < NUM_ELEMENTS)
        begin
            r = IDX_W'(uf_table[r].val);
            hops++;
        end
        hops = 0;
        while (x != r && !uf_table[x].is_root && hops < NUM_ELEMENTS)
        begin
            nxt             = IDX_W'(uf_table[x].val);
            uf_table[x].val = CNT_W'(r);
            x               = nxt;
            hops++;
        end
        return r;
    endfunction

    function automatic out_item_t apply_request(input logic op,
                                                input logic [ELEM_W-1:0] ea,
                                                input logic [ELEM_W-1:0] eb);
        logic [IDX_W-1:0] ra;
        logic [IDX_W-1:0] rb;
        out_item_t        res;
        ra           = locate_root(saturate_elem(ea));
        rb           = locate_root(saturate_elem(eb));
        res          = '0;
        res.same_set = (ra == rb);
        if (op == OP_UNITE && ra != rb)
        begin
            if (uf_table[ra].val > uf_table[rb].val)
            begin
                uf_table[ra].val = CNT_W'(uf_table[ra].val + uf_table[rb].val);
                uf_table[rb]     = '{1'b0, CNT_W'(ra)};
            end
            else
            begin
                // tie goes to the second element's root
                uf_table[rb].val = CNT_W'(uf_table[rb].val + uf_table[ra].val);
                uf_table[ra]     = '{1'b0, CNT_W'(rb)};
                ra               = rb;
            end
            res.merged = 1'b1;
        end
        res.root_a   = ROOT_W'(ra);
        res.set_size = SIZE_W'(uf_table[ra].val);
        return res;
    endfunction

    // Drive one query transfer; expectation is recorded at the accepting edge
    task automatic send_request(input logic op,
                                input logic [ELEM_W-1:0] ea,
                                input logic [ELEM_W-1:0] eb,
                                input bit typed,
                                input out_item_t typed_ans);
        out_item_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            query_ch.valid <= 1'b0;
            @(posedge clk);
        end
        query_ch.valid  <= 1'b1;
        query_ch.opcode <= op;
        query_ch.elem_a <= ea;
        query_ch.elem_b <= eb;
        @(posedge clk);
        while (!query_ch.ready)
            @(posedge clk);
        predicted = apply_request(op, ea, eb);
        answers_due.insert(answers_due.size(), typed ? typed_ans : predicted);
    endtask

    // Mostly a moving window so sets grow large and trees deepen; some
    // full-range picks join windows, some hit the index edges
    function automatic logic [ELEM_W-1:0] pick_elem(input int window_base);
        int mode;
        mode = $urandom_range(99);
        if (mode < 65)
            return ELEM_W'(window_base + $urandom_range(47));
        else if (mode < 88)
            return ELEM_W'($urandom_range(1023));
        else if (mode < 94)
            return ELEM_W'($urandom_range(3));
        return ELEM_W'(1020 + $urandom_range(3));
    endfunction

    // Answer side: check each transfer, then pick next cycle's ready
    initial
    begin
        out_item_t got;
        out_item_t want;
        answer_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && answer_ch.valid && answer_ch.ready)
            begin
                got = '{answer_ch.same_set, answer_ch.merged,
                        answer_ch.root_a, answer_ch.set_size};
                if (answers_due.size() == 0)
                begin
                    report_mismatch($sformatf("answer with nothing outstanding: %p", got));
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (got.same_set !== want.same_set)
                        report_mismatch($sformatf("same_set expected %0d got %0d",
                                                  want.same_set, got.same_set));
                    if (got.merged !== want.merged)
                        report_mismatch($sformatf("merged expected %0d got %0d",
                                                  want.merged, got.merged));
                    if (got.root_a !== want.root_a)
                        report_mismatch($sformatf("root_a expected %0d got %0d",
                                                  want.root_a, got.root_a));
                    if (got.set_size !== want.set_size)
                        report_mismatch($sformatf("set_size expected %0d got %0d",
                                                  want.set_size, got.set_size));
                end
            end
            answer_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        int window_base;
        rst_n           = 1'b0;
        query_ch.valid  = 1'b0;
        query_ch.opcode = OP_QUERY;
        query_ch.elem_a = '0;
        query_ch.elem_b = '0;
        clear_sets();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows run with no idling on either side
        foreach (DIRECTED_ROWS[i])
            send_request(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].a, DIRECTED_ROWS[i].b,
                         DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].ans);

        window_base = 0;
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            send_idle_pct  = SEND_IDLE_PCT[ph];
            recv_stall_pct = RECV_STALL_PCT[ph];
            for (int n = 0; n < RAND_PER_PHASE; n++)
            begin
                if (n % 100 == 0)
                    window_base = $urandom_range(1023 - 47);
                send_request(($urandom_range(99) < 55) ? OP_UNITE : OP_QUERY,
                             pick_elem(window_base), pick_elem(window_base),
                             1'b0, NO_ANS);
            end
        end
        query_ch.valid <= 1'b0;

        // Drain with the receiver free, then give any stray answer time to show
        recv_stall_pct = 0;
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("disjoint_set_union_find verification clean");
        else
            $display("disjoint_set_union_find verification failed");
        $finish;
    end

    // Hang guard
    initial
    begin
        #RUN_LIMIT_NS;
        $display("[%0t] timeout, %0d answers outstanding", $realtime, answers_due.size());
        $display("disjoint_set_union_find verification failed");
        $finish;
    end

endmodule
